### rtl/core/ditach_pkg.sv
package ditach_pkg;

  // input kind codes
  localparam logic [1:0] KIND_OVERFLOW = 2'd0;
  localparam logic [1:0] KIND_CAPTURE  = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;

  // configuration register indexes
  localparam logic REG_SPEED_NUMERATOR = 1'b0;
  localparam logic REG_TIMEOUT_TICKS   = 1'b1;

  localparam int NUM_W      = 24;
  localparam int TICK_W     = 16;
  localparam int CAP_IN_W   = 16;
  localparam int SPEED_W    = 30;
  localparam int DIVIDEND_W = NUM_W + 8;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [NUM_W-1:0]      NUM_RESET     = 24'd1562500;
  localparam logic [TICK_W-1:0]     TIMEOUT_RESET = 16'd500;
  localparam logic [TICK_W-1:0]     TICK_MAX      = 16'hFFFF;
  localparam logic [DIVIDEND_W-1:0] SPEED_LIMIT   = 32'd400000000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/core/ditach_div.sv
module ditach_div
  import ditach_pkg::*;
#(
  parameter int PERIOD_W = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [PERIOD_W-1:0]   divisor,
  output div_status_t           status,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic [PERIOD_W-1:0]   den;
  logic [PERIOD_W-1:0]   rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIV_CNT_W-1:0]  count;
  logic                  done;
  logic [PERIOD_W:0]     rem_sh;
  logic [PERIOD_W:0]     diff;
  logic                  ge;

  // one restoring step per cycle; a zero divisor yields all ones
  always_comb begin
    rem_sh = {rem, quo[DIVIDEND_W-1]};
    diff   = rem_sh - {1'b0, den};
    ge     = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den   <= divisor;
        rem   <= '0;
        quo   <= dividend;
        count <= DIV_CNT_W'(DIV_STEPS);
      end else if (count != '0) begin
        rem   <= ge ? diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
        quo   <= {quo[DIVIDEND_W-2:0], ge};
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = count != '0;
  assign status.done = done;
  assign quotient    = quo;

endmodule

### rtl/core/dual_input_capture_tachometer_unit.sv
// Channel  Handshake            Payload
// in       in_valid/in_ready    kind, channel, capture_value, direction_level
// out      out_valid/out_ready  left_speed, right_speed, speeds_fresh
// cfg      cfg_we               cfg_index, cfg_data (write only, no wait)
//
// A capture result passes these steps after accept: latch the period and
// register div_start, load the shared radix-2 divider, 32 divide steps, store
// the speed, load the output register. Other kinds go straight to the output
// register load. in_ready stays low until the output register loads.
// A stalled result sits in the output register; the next transaction may be
// taken meanwhile but its result waits for that register to drain.
// rst is synchronous: channel speeds clear, config returns to 1562500 and 500 ticks.
module dual_input_capture_tachometer_unit
  import ditach_pkg::*;
#(
  parameter int MAX_OVERFLOWS = 255,
  parameter int COUNTER_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic                      channel,
  input  logic [CAP_IN_W-1:0]       capture_value,
  input  logic                      direction_level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SPEED_W-1:0] left_speed,
  output logic signed [SPEED_W-1:0] right_speed,
  output logic                      speeds_fresh,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [NUM_W-1:0]          cfg_data
);

  localparam int OVF_W    = $clog2(MAX_OVERFLOWS + 1);
  localparam int PERIOD_W = OVF_W + COUNTER_BITS;
  localparam int CAP_W    = (COUNTER_BITS < CAP_IN_W) ? COUNTER_BITS : CAP_IN_W;
  localparam logic [OVF_W-1:0] OVF_MAX = OVF_W'(MAX_OVERFLOWS);

  typedef enum logic [1:0] {S_IDLE, S_DIVIDE, S_REPORT} state_t;

  state_t                     state;
  logic [NUM_W-1:0]           speed_numerator;
  logic [TICK_W-1:0]          timeout_ticks;
  logic [CAP_W-1:0]           last_capture [2];
  logic [OVF_W-1:0]           overflow_count [2];
  logic signed [SPEED_W-1:0]  channel_speed [2];
  logic [TICK_W-1:0]          idle_ticks;
  logic                       cap_ch;
  logic                       cap_fwd;
  logic                       div_start;
  logic [PERIOD_W-1:0]        period;
  div_status_t                div_status;
  logic [DIVIDEND_W-1:0]      quotient;

  logic                       accept;
  logic [CAP_W-1:0]           cap_val;
  logic [COUNTER_BITS-1:0]    wrap_diff;
  logic [PERIOD_W-1:0]        period_next;
  logic [SPEED_W-1:0]         mag;
  logic signed [SPEED_W-1:0]  speed_next;
  logic                       fresh;

  assign accept   = in_valid && in_ready;
  assign in_ready = state == S_IDLE;
  assign cap_val  = capture_value[CAP_W-1:0];

  always_comb begin
    wrap_diff = COUNTER_BITS'(cap_val) - COUNTER_BITS'(last_capture[channel]);
    if (overflow_count[channel] != '0) begin
      period_next = {overflow_count[channel], {COUNTER_BITS{1'b0}}}
                    - PERIOD_W'(last_capture[channel]) + PERIOD_W'(cap_val);
    end else begin
      period_next = PERIOD_W'(wrap_diff);
    end
  end

  // zero period comes back as all ones and clamps to the limit
  always_comb begin
    mag        = (quotient > SPEED_LIMIT) ? SPEED_LIMIT[SPEED_W-1:0]
                                          : quotient[SPEED_W-1:0];
    speed_next = cap_fwd ? $signed(mag) : -$signed(mag);
    fresh      = idle_ticks < timeout_ticks;
  end

  ditach_div #(
    .PERIOD_W (PERIOD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({speed_numerator, 8'd0}),
    .divisor  (period),
    .status   (div_status),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_numerator <= NUM_RESET;
      timeout_ticks   <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_NUMERATOR: speed_numerator <= cfg_data;
        REG_TIMEOUT_TICKS:   timeout_ticks   <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      div_start         <= 1'b0;
      out_valid         <= 1'b0;
      idle_ticks        <= '0;
      last_capture[0]   <= '0;
      last_capture[1]   <= '0;
      overflow_count[0] <= '0;
      overflow_count[1] <= '0;
      channel_speed[0]  <= '0;
      channel_speed[1]  <= '0;
    end else begin
      div_start <= accept && (kind == KIND_CAPTURE);
      out_valid <= (state == S_REPORT) || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (kind == KIND_CAPTURE) ? S_DIVIDE : S_REPORT;
            case (kind)
              KIND_OVERFLOW: begin
                for (int i = 0; i < 2; i++) begin
                  if (overflow_count[i] != OVF_MAX) begin
                    overflow_count[i] <= overflow_count[i] + 1'b1;
                  end
                end
              end
              KIND_CAPTURE: begin
                period                  <= period_next;
                cap_ch                  <= channel;
                cap_fwd                 <= direction_level;
                last_capture[channel]   <= cap_val;
                overflow_count[channel] <= '0;
                idle_ticks              <= '0;
              end
              KIND_TICK: begin
                if (idle_ticks != TICK_MAX) begin
                  idle_ticks <= idle_ticks + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIVIDE: begin
          if (div_status.done) begin
            channel_speed[cap_ch] <= speed_next;
            state                 <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (!out_valid || out_ready) begin
            speeds_fresh <= fresh;
            left_speed   <= fresh ? channel_speed[0] : '0;
            right_speed  <= fresh ? channel_speed[1] : '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/ditach_checker.sv
module ditach_checker
  import ditach_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [SPEED_W-1:0] left_speed,
  input logic signed [SPEED_W-1:0] right_speed,
  input logic                      speeds_fresh
);

  localparam logic signed [SPEED_W-1:0] LIM = SPEED_LIMIT[SPEED_W-1:0];

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_speed)
      && $stable(right_speed) && $stable(speeds_fresh))
    else $error("stalled result changed");

  a_stale_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !speeds_fresh |-> left_speed == '0 && right_speed == '0)
    else $error("timed-out speeds not zero");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_speed <= LIM && left_speed >= -LIM
      && right_speed <= LIM && right_speed >= -LIM)
    else $error("speed beyond limit");

endmodule

bind dual_input_capture_tachometer_unit ditach_checker u_ditach_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .left_speed   (left_speed),
  .right_speed  (right_speed),
  .speeds_fresh (speeds_fresh)
);

### tb/tb_dual_input_capture_tachometer_unit.sv
`timescale 1ns / 100ps

module tb_dual_input_capture_tachometer_unit;
  import ditach_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused code, state must not move
  localparam int MAX_OVF = 255;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [1:0]  kind;
    logic        chan;
    logic [15:0] cap;
    logic        dir;
    int          gap;
  } tach_event_t;

  typedef struct {
    logic signed [SPEED_W-1:0] left_spd;
    logic signed [SPEED_W-1:0] right_spd;
    logic                      fresh;
  } tach_reading_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                kind = KIND_OVERFLOW;
  logic                      channel = 1'b0;
  logic [CAP_IN_W-1:0]       capture_value = '0;
  logic                      direction_level = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic                      speeds_fresh;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = REG_SPEED_NUMERATOR;
  logic [NUM_W-1:0]          cfg_data = '0;

  dual_input_capture_tachometer_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .channel         (channel),
    .capture_value   (capture_value),
    .direction_level (direction_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .left_speed      (left_speed),
    .right_speed     (right_speed),
    .speeds_fresh    (speeds_fresh),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [NUM_W-1:0]          num_cfg = NUM_RESET;
  logic [TICK_W-1:0]         timeout_cfg = TIMEOUT_RESET;
  logic [15:0]               prev_cap [2] = '{16'd0, 16'd0};
  logic [7:0]                ovf_cnt [2] = '{8'd0, 8'd0};
  logic signed [SPEED_W-1:0] chan_speed [2] = '{'0, '0};
  logic [TICK_W-1:0]         idle_cnt = '0;

  tach_event_t   pending_events[$];
  tach_reading_t expected_readings[$];
  tach_event_t   drv_ev;
  int            n_queued = 0;
  int            n_accepted = 0;
  int            n_errors = 0;
  int            stall_cycles = 0;
  int            gap_cnt = 0;
  int            out_hold = 0;
  logic          in_took = 1'b0;
  logic          no_idle = 1'b0;
  longint        motor_ctr = 0;

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic void advance_tach(tach_event_t ev);
    tach_reading_t             r;
    logic [63:0]               period;
    logic [63:0]               quot;
    logic [15:0]               diff;
    logic signed [SPEED_W-1:0] s;
    logic                      fresh;
    int                        c;
    case (ev.kind)
      KIND_OVERFLOW: begin
        for (c = 0; c < 2; c++)
          if (ovf_cnt[c] < MAX_OVF) ovf_cnt[c]++;
      end
      KIND_CAPTURE: begin
        c = ev.chan;
        if (ovf_cnt[c] != 0) begin
          period = 64'(ovf_cnt[c]) * 64'd65536 - 64'(prev_cap[c]) + 64'(ev.cap);
        end else begin
          diff = ev.cap - prev_cap[c];
          period = 64'(diff);
        end
        if (period == 0) begin
          quot = 64'(SPEED_LIMIT);
        end else begin
          quot = {32'd0, num_cfg, 8'd0} / period;
          if (quot > 64'(SPEED_LIMIT)) quot = 64'(SPEED_LIMIT);
        end
        s = quot[SPEED_W-1:0];
        chan_speed[c] = ev.dir ? s : -s;
        prev_cap[c] = ev.cap;
        ovf_cnt[c] = '0;
        idle_cnt = '0;
      end
      KIND_TICK: begin
        if (idle_cnt != TICK_MAX) idle_cnt++;
      end
      default: ;
    endcase
    fresh = idle_cnt < timeout_cfg;
    r.left_spd = fresh ? chan_speed[0] : '0;
    r.right_spd = fresh ? chan_speed[1] : '0;
    r.fresh = fresh;
    expected_readings.push_back(r);
  endfunction

  // input side: hold until accepted, then wait the drawn gap of the next transaction
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_events.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_cnt < pending_events[0].gap) begin
        in_valid <= 1'b0;
        gap_cnt <= gap_cnt + 1;
      end else begin
        drv_ev = pending_events.pop_front();
        kind <= drv_ev.kind;
        channel <= drv_ev.chan;
        capture_value <= drv_ev.cap;
        direction_level <= drv_ev.dir;
        in_valid <= 1'b1;
        gap_cnt <= 0;
      end
    end
  end

  // output side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tach_reading_t exp_r;
    tach_event_t   acc_ev;
    in_took <= !rst && in_valid && in_ready;
    if (!rst) begin
      stall_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                      0 : stall_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          flag_mismatch("result with no transaction outstanding");
        end else begin
          exp_r = expected_readings.pop_front();
          if (left_speed !== exp_r.left_spd)
            flag_mismatch($sformatf("left_speed %0d, expected %0d",
                                    left_speed, exp_r.left_spd));
          if (right_speed !== exp_r.right_spd)
            flag_mismatch($sformatf("right_speed %0d, expected %0d",
                                    right_speed, exp_r.right_spd));
          if (speeds_fresh !== exp_r.fresh)
            flag_mismatch($sformatf("speeds_fresh %0b, expected %0b",
                                    speeds_fresh, exp_r.fresh));
        end
        out_hold <= no_idle ? 0 : $urandom_range(0, 5);
      end
      if (in_valid && in_ready) begin
        acc_ev.kind = kind;
        acc_ev.chan = channel;
        acc_ev.cap = capture_value;
        acc_ev.dir = direction_level;
        acc_ev.gap = 0;
        advance_tach(acc_ev);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic queue_event(logic [1:0] k, logic ch, logic [15:0] cap, logic dir);
    tach_event_t ev;
    ev.kind = k;
    ev.chan = ch;
    ev.cap = cap;
    ev.dir = dir;
    ev.gap = no_idle ? 0 : $urandom_range(0, 5);
    pending_events.push_back(ev);
    n_queued++;
  endtask

  task automatic queue_noise(logic [1:0] k);
    queue_event(k, 1'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // block idle: every transaction taken and every result back, then latency margin
  task automatic settle();
    do @(negedge clk); while (n_accepted != n_queued || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [NUM_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_SPEED_NUMERATOR) num_cfg = data;
    else timeout_cfg = data[TICK_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [NUM_W-1:0] num, logic [TICK_W-1:0] tmo);
    settle();
    write_reg(REG_SPEED_NUMERATOR, num);
    write_reg(REG_TIMEOUT_TICKS, {8'($urandom), tmo});
  endtask

  // shared free-running counter; overflows land between edges as in hardware
  task automatic run_motor(int n_edges);
    int     k;
    longint delta;
    longint wraps;
    logic   ch;
    logic   fwd;
    ch = 1'($urandom);
    fwd = 1'($urandom);
    for (k = 0; k < n_edges; k++) begin
      case ($urandom_range(0, 3))
        0: delta = $urandom_range(0, 300);
        1: delta = $urandom_range(300, 20000);
        2: delta = $urandom_range(20000, 140000);
        default: delta = $urandom_range(140000, 400000);
      endcase
      wraps = ((motor_ctr + delta) >> 16) - (motor_ctr >> 16);
      motor_ctr = motor_ctr + delta;
      repeat (wraps) queue_noise(KIND_OVERFLOW);
      if ($urandom_range(0, 3) == 0) queue_noise(KIND_TICK);
      if ($urandom_range(0, 7) == 0) ch = ~ch;
      if ($urandom_range(0, 9) == 0) fwd = ~fwd;
      queue_event(KIND_CAPTURE, ch, motor_ctr[15:0], fwd);
    end
  endtask

  task automatic random_phase(int budget);
    int stop_at;
    int burst;
    int pick;
    stop_at = n_queued + budget;
    while (n_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        run_motor($urandom_range(1, 8));
      end else if (pick < 65) begin
        burst = (timeout_cfg < 40) ? $urandom_range(0, timeout_cfg + 3) : $urandom_range(0, 40);
        repeat (burst) queue_noise(KIND_TICK);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) queue_noise(KIND_OVERFLOW);
      end else if (pick < 80) begin
        queue_noise(KIND_SPARE);
      end else begin
        queue_noise(2'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: defaults after reset
    queue_noise(KIND_TICK);
    queue_noise(KIND_SPARE);
    queue_event(KIND_CAPTURE, 1'b0, 16'h0000, 1'b1);  // zero period
    queue_event(KIND_CAPTURE, 1'b1, 16'hFFFF, 1'b0);
    queue_event(KIND_CAPTURE, 1'b0, 16'h0001, 1'b1);  // one tick, reaches the limit
    queue_event(KIND_OVERFLOW, 1'b1, 16'hFFFF, 1'b1);
    queue_event(KIND_CAPTURE, 1'b0, 16'h0000, 1'b0);
    queue_event(KIND_CAPTURE, 1'b1, 16'h0000, 1'b1);  // wraps after one overflow
    queue_event(KIND_OVERFLOW, 1'b0, 16'h0000, 1'b0);
    queue_event(KIND_OVERFLOW, 1'b0, 16'h0000, 1'b0);
    queue_event(KIND_CAPTURE, 1'b1, 16'hFFFF, 1'b1);
    queue_event(KIND_CAPTURE, 1'b0, 16'h8000, 1'b1);
    queue_event(KIND_CAPTURE, 1'b0, 16'h7FFF, 1'b0);
    queue_noise(KIND_SPARE);

    configure(24'hFFFFFF, 16'd1);
    queue_noise(KIND_TICK);  // times out at once
    queue_noise(KIND_SPARE);
    queue_event(KIND_CAPTURE, 1'b1, 16'h0005, 1'b1);
    queue_event(KIND_CAPTURE, 1'b1, 16'h0006, 1'b0);
    queue_noise(KIND_TICK);
    queue_noise(KIND_TICK);

    configure(24'd1, 16'd2);
    queue_event(KIND_CAPTURE, 1'b0, 16'h1234, 1'b1);
    queue_event(KIND_CAPTURE, 1'b0, 16'h1235, 1'b0);
    queue_noise(KIND_TICK);
    queue_noise(KIND_TICK);

    // overflow count saturation, both channels
    configure(NUM_RESET, TIMEOUT_RESET);
    repeat (300) queue_noise(KIND_OVERFLOW);
    queue_event(KIND_CAPTURE, 1'b0, 16'hFFFF, 1'b1);
    queue_event(KIND_CAPTURE, 1'b1, 16'h0000, 1'b0);
    repeat (255) queue_noise(KIND_OVERFLOW);
    queue_event(KIND_CAPTURE, 1'b0, 16'h0000, 1'b0);

    configure(NUM_RESET, TIMEOUT_RESET);
    random_phase(150);
    configure(24'hFFFFFF, 16'hFFFF);
    random_phase(150);
    configure(24'd1, 16'd1);
    random_phase(150);
    configure(24'($urandom), 16'($urandom_range(2, 30)));
    random_phase(150);
    configure(24'($urandom), 16'($urandom_range(2, 30)));
    no_idle = 1'b1;
    random_phase(150);
    configure(24'($urandom_range(1, 24'hFFFFFF)), TIMEOUT_RESET);
    no_idle = 1'b0;
    random_phase(150);

    settle();
    if (expected_readings.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_readings.size()));
    if (n_errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### dual_input_capture_tachometer_unit.f
rtl/core/ditach_pkg.sv
rtl/core/ditach_div.sv
rtl/core/dual_input_capture_tachometer_unit.sv
rtl/core/ditach_checker.sv
tb/tb_dual_input_capture_tachometer_unit.sv
